/* hdl/sbfr_pkg.sv */
// Shared types and constants for the servo bus frame receiver.
`default_nettype none

package sbfr_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned NUM_PARAMS  = 4;
    localparam int unsigned PIDX_W      = 2;
    localparam int unsigned POS_W       = 4;
    localparam int unsigned LEN_W       = 3;
    localparam int unsigned CNT_W       = 3;
    localparam int unsigned OUT_DATA_W  = 56;
    localparam int unsigned OUT_USER_W  = 1;

    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h55;
    localparam logic [BYTE_W-1:0] MIN_LEN      = 8'd3;
    localparam logic [BYTE_W-1:0] MAX_LEN      = 8'd7;

    // byte positions within a frame
    localparam logic [POS_W-1:0] POS_HUNT  = 4'd0;
    localparam logic [POS_W-1:0] POS_ID    = 4'd2;
    localparam logic [POS_W-1:0] POS_LEN   = 4'd3;
    localparam logic [POS_W-1:0] POS_CMD   = 4'd4;
    localparam logic [POS_W-1:0] POS_PARAM = 4'd5;
    localparam logic [POS_W-1:0] POS_PEND  = 4'd9;

    localparam logic [LEN_W-1:0] LEN_IDLE  = 3'd2;

    localparam logic STATUS_GOOD = 1'b0;
    localparam logic STATUS_BAD  = 1'b1;

    typedef logic [BYTE_W-1:0] t_byte;

    typedef struct packed {
        logic              status;
        t_byte             servo_id;
        t_byte             command;
        logic [CNT_W-1:0]  param_count;
        t_byte             param_a;
        t_byte             param_b;
        t_byte             param_c;
        t_byte             param_d;
    } t_result;

endpackage

`default_nettype wire

/* hdl/servo_bus_frame_receiver.sv */
// Top level of the servo bus frame receiver.
//
//  channel   dir   handshake                      payload
//  s_axis    in    s_axis_tvalid / s_axis_tready  tdata[7:0] rx_byte
//  m_axis    out   m_axis_tvalid / m_axis_tready  tdata ids/command/params, tuser status
//  cfg       in    i_cfg_valid / o_cfg_ready      i_cfg_data header_byte
//
// One byte item per cycle unless held off; a result appears in the cycle after its checksum byte.
// Input is held off only while a result sits in the output register and the sink stalls.
// Reset (synchronous, active low) returns to header hunt with header 0x55.
// Config is always ready and applies from the next byte.
`default_nettype none

module servo_bus_frame_receiver
    import sbfr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [BYTE_W-1:0]     s_axis_tdata,  // [7:0] rx_byte
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [7:0] servo_id, [15:8] command, [18:16] param_count, [26:19] param_a,
    // [34:27] param_b, [42:35] param_c, [50:43] param_d, [55:51] zero
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    output logic [OUT_USER_W-1:0]      m_axis_tuser,  // [0] status
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [BYTE_W-1:0]     i_cfg_data     // header_byte
);

    t_byte   r_header_byte;
    logic    w_accept;
    logic    w_res_valid;
    logic    w_free;
    t_result w_result;
    t_result w_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_byte <= HEADER_RESET;
        end else if (i_cfg_valid) begin
            r_header_byte <= i_cfg_data;
        end
    end

    assign s_axis_tready = w_free;
    assign w_accept      = s_axis_tvalid && w_free;

    sbfr_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_rx_byte     (s_axis_tdata),
        .i_header_byte (r_header_byte),
        .o_res_valid   (w_res_valid),
        .o_result      (w_result)
    );

    sbfr_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_res_valid),
        .i_result (w_result),
        .i_take   (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_free   (w_free),
        .o_result (w_out)
    );

    assign m_axis_tdata = {5'b0, w_out.param_d, w_out.param_c, w_out.param_b,
                           w_out.param_a, w_out.param_count, w_out.command,
                           w_out.servo_id};
    assign m_axis_tuser = w_out.status;

endmodule

`default_nettype wire

/* hdl/sbfr_parser.sv */
// Frame parser: header hunt, field capture, running checksum.
`default_nettype none

module sbfr_parser
    import sbfr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_accept,
    input  wire t_byte   i_rx_byte,
    input  wire t_byte   i_header_byte,
    output logic         o_res_valid,
    output t_result      o_result
);

    logic             r_in_frame, n_in_frame;
    logic             r_header_seen, n_header_seen;
    logic [POS_W-1:0] r_byte_index, n_byte_index;
    logic [LEN_W-1:0] r_frame_length, n_frame_length;
    t_byte            r_running_sum, n_running_sum;
    t_byte            r_held_id, n_held_id;
    t_byte            r_held_command, n_held_command;
    t_byte            r_held_params [NUM_PARAMS];
    t_byte            n_held_params [NUM_PARAMS];

    logic [POS_W-1:0]  w_last_pos;
    logic [PIDX_W-1:0] w_pidx;
    t_byte             w_sum_add;

    assign w_last_pos = {1'b0, r_frame_length} + POS_W'(2);
    assign w_pidx     = PIDX_W'(r_byte_index - POS_PARAM);
    assign w_sum_add  = r_running_sum + i_rx_byte;

    always_comb begin
        n_in_frame     = r_in_frame;
        n_header_seen  = r_header_seen;
        n_byte_index   = r_byte_index;
        n_frame_length = r_frame_length;
        n_running_sum  = r_running_sum;
        n_held_id      = r_held_id;
        n_held_command = r_held_command;
        n_held_params  = r_held_params;
        o_res_valid    = 1'b0;

        o_result.status      = (~r_running_sum == i_rx_byte) ? STATUS_GOOD : STATUS_BAD;
        o_result.servo_id    = r_held_id;
        o_result.command     = r_held_command;
        o_result.param_count = CNT_W'(r_frame_length - LEN_W'(MIN_LEN));
        o_result.param_a     = r_held_params[0];
        o_result.param_b     = r_held_params[1];
        o_result.param_c     = r_held_params[2];
        o_result.param_d     = r_held_params[3];

        if (i_accept) begin
            if (!r_in_frame) begin
                if (i_rx_byte == i_header_byte) begin
                    if (r_header_seen) begin
                        n_header_seen = 1'b0;
                        n_in_frame    = 1'b1;
                        n_byte_index  = POS_ID;
                    end else begin
                        n_header_seen = 1'b1;
                    end
                end else begin
                    n_header_seen = 1'b0;
                end
            end else begin
                case (r_byte_index)
                    POS_ID: begin
                        n_held_id     = i_rx_byte;
                        n_running_sum = i_rx_byte;
                        n_byte_index  = POS_LEN;
                    end
                    POS_LEN: begin
                        if (i_rx_byte < MIN_LEN || i_rx_byte > MAX_LEN) begin
                            n_in_frame     = 1'b0;
                            n_header_seen  = 1'b0;
                            n_byte_index   = POS_HUNT;
                            n_frame_length = LEN_IDLE;
                        end else begin
                            n_frame_length = i_rx_byte[LEN_W-1:0];
                            n_running_sum  = w_sum_add;
                            for (int k = 0; k < NUM_PARAMS; k++) begin
                                n_held_params[k] = '0;
                            end
                            n_byte_index = POS_CMD;
                        end
                    end
                    POS_CMD: begin
                        n_held_command = i_rx_byte;
                        n_running_sum  = w_sum_add;
                        n_byte_index   = POS_PARAM;
                    end
                    default: begin
                        if (r_byte_index < POS_PARAM || r_byte_index > w_last_pos) begin
                            n_in_frame     = 1'b0;
                            n_header_seen  = 1'b0;
                            n_byte_index   = POS_HUNT;
                            n_frame_length = LEN_IDLE;
                        end else if (r_byte_index < w_last_pos) begin
                            if (r_byte_index < POS_PEND) begin
                                n_held_params[w_pidx] = i_rx_byte;
                            end
                            n_running_sum = w_sum_add;
                            n_byte_index  = r_byte_index + POS_W'(1);
                        end else begin
                            // checksum byte
                            o_res_valid    = 1'b1;
                            n_in_frame     = 1'b0;
                            n_header_seen  = 1'b0;
                            n_byte_index   = POS_HUNT;
                            n_frame_length = LEN_IDLE;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame     <= 1'b0;
            r_header_seen  <= 1'b0;
            r_byte_index   <= POS_HUNT;
            r_frame_length <= LEN_IDLE;
        end else begin
            r_in_frame     <= n_in_frame;
            r_header_seen  <= n_header_seen;
            r_byte_index   <= n_byte_index;
            r_frame_length <= n_frame_length;
        end
    end

    always_ff @(posedge i_clk) begin
        r_running_sum  <= n_running_sum;
        r_held_id      <= n_held_id;
        r_held_command <= n_held_command;
        r_held_params  <= n_held_params;
    end

endmodule

`default_nettype wire

/* hdl/sbfr_out_reg.sv */
// Result register holding one finished item until the sink takes it.
`default_nettype none

module sbfr_out_reg
    import sbfr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_result,
    input  wire logic    i_take,
    output logic         o_valid,
    output logic         o_free,
    output t_result      o_result
);

    logic    r_valid, n_valid;
    t_result r_result;

    assign o_free = !r_valid || i_take;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

/* hdl/sbfr_checker.sv */
// Port-level checks for the servo bus frame receiver, bound to the top level.
`default_nettype none

module sbfr_checker
    import sbfr_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  s_axis_tvalid,
    input wire logic                  s_axis_tready,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // an empty output slot never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // nothing pending after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // a result needs at least one accepted byte since the last one was taken
    a_result_from_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!m_axis_tvalid && !(s_axis_tvalid && s_axis_tready)) |=> !m_axis_tvalid)
        else $error("result without input byte");

    // result held while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind servo_bus_frame_receiver sbfr_checker u_sbfr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the servo bus frame receiver: byte stream in, frame results out.
`timescale 1ns / 100ps

module testbench;
    import sbfr_pkg::*;

    typedef struct {
        t_byte   rx;
        bit      typed;
        t_result want;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata;   // [7:0] rx_byte
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // [7:0] servo_id, [15:8] command, [18:16] param_count, [26:19] param_a,
    // [34:27] param_b, [42:35] param_c, [50:43] param_d, [55:51] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;   // [0] status
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [BYTE_W-1:0]     i_cfg_data;

    servo_bus_frame_receiver dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // frame tracker state
    t_byte            hdr_val;
    bit               framing;
    bit               hdr_pending;
    logic [POS_W-1:0] pos;
    t_byte            flen;
    t_byte            csum;
    t_byte            held_id;
    t_byte            held_cmd;
    t_byte            held_par [NUM_PARAMS];

    t_result pending_frames [$];
    t_row    rows [$];
    int      n_bad = 0;
    int      n_sent = 0;
    bit      idle_on = 1'b1;

    task automatic hunt_restart();
        framing     = 1'b0;
        hdr_pending = 1'b0;
        pos         = POS_HUNT;
        flen        = 8'd2;
    endtask

    task automatic frame_track(input t_byte b, output bit done, output t_result r);
        int    k;
        int    cnt;
        t_byte inv;
        done = 1'b0;
        r    = '0;
        if (!framing) begin
            if (b == hdr_val) begin
                if (hdr_pending) begin
                    hdr_pending = 1'b0;
                    framing     = 1'b1;
                    pos         = POS_ID;
                end else begin
                    hdr_pending = 1'b1;
                end
            end else begin
                hdr_pending = 1'b0;
            end
        end else if (pos == POS_ID) begin
            held_id = b;
            csum    = b;
            pos     = POS_LEN;
        end else if (pos == POS_LEN) begin
            if (b < MIN_LEN || b > MAX_LEN) begin
                hunt_restart();
            end else begin
                flen = b;
                csum = csum + b;
                foreach (held_par[i]) held_par[i] = '0;
                pos = POS_CMD;
            end
        end else if (pos == POS_CMD) begin
            held_cmd = b;
            csum     = csum + b;
            pos      = POS_PARAM;
        end else if (int'(pos) < int'(flen) + 2) begin
            k = int'(pos) - int'(POS_PARAM);
            if (k < NUM_PARAMS) held_par[k] = b;
            csum = csum + b;
            pos  = pos + 1'b1;
        end else begin
            inv               = ~csum;
            cnt               = int'(flen) - int'(MIN_LEN);
            done              = 1'b1;
            r.status          = (inv == b) ? STATUS_GOOD : STATUS_BAD;
            r.servo_id        = held_id;
            r.command         = held_cmd;
            r.param_count     = cnt[CNT_W-1:0];
            r.param_a         = (cnt > 0) ? held_par[0] : '0;
            r.param_b         = (cnt > 1) ? held_par[1] : '0;
            r.param_c         = (cnt > 2) ? held_par[2] : '0;
            r.param_d         = (cnt > 3) ? held_par[3] : '0;
            hunt_restart();
        end
    endtask

    function automatic int src_gap();
        int sel;
        if (!idle_on) return 0;
        sel = $urandom_range(0, 99);
        if (sel < 60) return 0;
        if (sel < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_byte(input t_byte b, input bit use_typed, input t_result typed);
        int      gap;
        bit      done;
        t_result r;
        gap = src_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        n_sent++;
        frame_track(b, done, r);
        if (use_typed) pending_frames.push_back(typed);
        else if (done) pending_frames.push_back(r);
    endtask

    task automatic feed(input t_byte b);
        send_byte(b, 1'b0, '0);
    endtask

    task automatic add_row(input t_byte b);
        rows.push_back('{b, 1'b0, '0});
    endtask

    task automatic write_header(input t_byte v);
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        hdr_val = v;
    endtask

    task automatic cmp_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %02h, got %02h", $time, name, want, got);
            n_bad++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
            got = {m_axis_tuser[0], m_axis_tdata[7:0], m_axis_tdata[15:8],
                   m_axis_tdata[18:16], m_axis_tdata[26:19], m_axis_tdata[34:27],
                   m_axis_tdata[42:35], m_axis_tdata[50:43]};
            if (pending_frames.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, got);
                n_bad++;
            end else begin
                want = pending_frames.pop_front();
                cmp_field("status", 8'(want.status), 8'(got.status));
                cmp_field("servo_id", want.servo_id, got.servo_id);
                cmp_field("command", want.command, got.command);
                cmp_field("param_count", 8'(want.param_count), 8'(got.param_count));
                cmp_field("param_a", want.param_a, got.param_a);
                cmp_field("param_b", want.param_b, got.param_b);
                cmp_field("param_c", want.param_c, got.param_c);
                cmp_field("param_d", want.param_d, got.param_d);
            end
        end
    end

    // sink backpressure
    initial begin
        int run;
        bit rdy;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (!idle_on || $urandom_range(0, 99) < 70) begin
                rdy = 1'b1;
                run = $urandom_range(1, 20);
            end else begin
                rdy = 1'b0;
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 3);
            end
            m_axis_tready <= rdy;
            repeat (run) @(posedge i_clk);
        end
    end

    initial begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        t_byte hv;
        t_byte id;
        t_byte len;
        t_byte cmd;
        t_byte sum;
        t_byte ck;
        t_byte x;
        int    sel;
        int    base;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;

        hdr_val  = HEADER_RESET;
        hunt_restart();
        csum     = '0;
        held_id  = '0;
        held_cmd = '0;
        foreach (held_par[i]) held_par[i] = '0;

        // minimum-length frame with no parameters, all-zero fields, wrong checksum
        add_row(8'h55); add_row(8'h55); add_row(8'h00); add_row(8'h03); add_row(8'h00);
        rows.push_back('{8'h00, 1'b1,
                         '{STATUS_BAD, 8'h00, 8'h00, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00}});
        // third header taken as id, longest frame, good checksum
        add_row(8'h55); add_row(8'h55); add_row(8'h55); add_row(8'h07); add_row(8'hFF);
        add_row(8'hFF); add_row(8'h00); add_row(8'h80); add_row(8'h01);
        rows.push_back('{8'h24, 1'b1,
                         '{STATUS_GOOD, 8'h55, 8'hFF, 3'd4, 8'hFF, 8'h00, 8'h80, 8'h01}});
        // length too large drops the frame
        add_row(8'h55); add_row(8'h55); add_row(8'h12); add_row(8'h08);
        // frame left open across the header change below
        add_row(8'h55); add_row(8'h55); add_row(8'h10); add_row(8'h03);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) send_byte(rows[i].rx, rows[i].typed, rows[i].want);
        s_axis_tvalid <= 1'b0;

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: hv = 8'h00;
                1: hv = 8'hFF;
                4: hv = HEADER_RESET;
                default: hv = t_byte'($urandom_range(0, 255));
            endcase
            write_header(hv);
            idle_on = (ph != 3);
            base = n_sent;
            while (n_sent - base < 390) begin
                sel = $urandom_range(0, 99);
                if (sel < 75) begin
                    feed(hv);
                    feed(hv);
                    id  = ($urandom_range(0, 9) == 0) ? hv : t_byte'($urandom_range(0, 255));
                    len = t_byte'($urandom_range(3, 7));
                    cmd = t_byte'($urandom_range(0, 255));
                    feed(id);
                    feed(len);
                    feed(cmd);
                    sum = id + len + cmd;
                    for (int k = 0; k < int'(len) - 3; k++) begin
                        x = t_byte'($urandom_range(0, 255));
                        feed(x);
                        sum = sum + x;
                    end
                    ck = ~sum;
                    if ($urandom_range(0, 4) == 0) ck = t_byte'($urandom_range(0, 255));
                    feed(ck);
                end else if (sel < 85) begin
                    feed(hv);
                    feed(hv);
                    feed(t_byte'($urandom_range(0, 255)));
                    feed(($urandom_range(0, 1) == 0) ? t_byte'($urandom_range(0, 2))
                                                     : t_byte'($urandom_range(8, 255)));
                end else if (sel < 92) begin
                    feed(hv);
                    feed(t_byte'($urandom_range(0, 255)));
                end else begin
                    repeat ($urandom_range(1, 6)) feed(t_byte'($urandom_range(0, 255)));
                end
            end
            s_axis_tvalid <= 1'b0;
        end

        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (n_bad == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
